// ----- hw/rtl/weighted_section_interleaver_defines.svh -----
// ----------------------------------------------------------------------------
// weighted_section_interleaver_defines
// Assertion helpers for the section interleaver.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SECTION_INTERLEAVER_DEFINES_SVH
`define WEIGHTED_SECTION_INTERLEAVER_DEFINES_SVH

// same-cycle implication
`define WSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wsi_pkg.sv -----
// ----------------------------------------------------------------------------
// wsi_pkg
// Types, codes and sizes shared by the section interleaver.
// ----------------------------------------------------------------------------
package wsi_pkg;

  localparam int MEMBERS          = 8;
  localparam int FRAME_COUNT_BITS = 20;
  localparam int TOT_W            = FRAME_COUNT_BITS + 1;
  localparam int IDX_W            = $clog2(MEMBERS);
  localparam int CNT_W            = $clog2(MEMBERS + 1);
  localparam int CFG_W            = 4;
  localparam int GROUP_W          = 24;
  localparam int PROD_W           = 2 * TOT_W;
  localparam logic [GROUP_W-1:0] GROUP_MAX = {GROUP_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_RESTART = 2'd1,
    ACT_EMIT    = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MUL_A,
    ST_MUL_B,
    ST_CMP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  member_index;
    logic [20:0] member_frames;
    logic        frame_starts_section;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  chosen_member;
    logic [19:0] frame_position;
    logic        new_section;
    logic        group_done;
    logic        mix_error;
  } out_item_t;

endpackage

// ----- hw/rtl/weighted_section_interleaver.sv -----
// ----------------------------------------------------------------------------
// weighted_section_interleaver
// Load/restart beats act on accept; the block stays idle. An emit beat that
// stays in the open section passes CHECK, EMIT; a new-section pick passes
// CHECK, SCAN (with MUL_A, MUL_B, CMP per unfinished member after the first),
// EMIT. Next beat accepted the cycle after the result is loaded; a stalled
// result holds the block. Reset (async, active low) clears all, member_count=1.
// ----------------------------------------------------------------------------
`include "weighted_section_interleaver_defines.svh"

module weighted_section_interleaver import wsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  // input beats
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  // result beats
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  // member_count register
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [TOT_W-1:0]   member_total_q   [MEMBERS];
  logic [TOT_W-1:0]   member_written_q [MEMBERS];
  logic [GROUP_W-1:0] group_total_q, group_written_q;
  logic [IDX_W-1:0]   cur_q;
  logic               sec_open_q;
  logic [CFG_W-1:0]   member_count_q;

  // per-item working registers
  logic               fss_q;       // latched frame_starts_section
  logic [CNT_W-1:0]   j_q;         // scan index, can reach n
  logic               found_q;
  logic [IDX_W-1:0]   best_q;      // chosen member
  logic [TOT_W-1:0]   best_t_q, best_w_q;
  logic [PROD_W-1:0]  prod_a_q, prod_b_q;
  logic               new_sec_q;
  logic               err_q;

  out_item_t          out_q;
  logic               out_valid_q;

  // --------------------------------------------------------------------------
  // Shared read port, multiplier and derived terms
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0]  rd_addr;
  logic [TOT_W-1:0]  w_rd, t_rd;
  logic [TOT_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] product;
  logic [CNT_W-1:0]  n_eff;
  logic              rd_unfinished;
  logic              stay_in_section;
  logic              scan_end;
  logic              out_free;
  logic              in_fire;

  assign w_rd          = member_written_q[rd_addr];
  assign t_rd          = member_total_q[rd_addr];
  assign rd_unfinished = w_rd < t_rd;
  assign product       = PROD_W'(mul_a) * PROD_W'(mul_b);

  // member_count above the member limit is clamped
  assign n_eff = (member_count_q > CFG_W'(MEMBERS)) ? CNT_W'(MEMBERS)
                                                    : CNT_W'(member_count_q);

  assign stay_in_section = sec_open_q && ({1'b0, cur_q} < n_eff) &&
                           rd_unfinished && !fss_q;
  assign scan_end = j_q >= n_eff;
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_fire  = in_valid_i && !in_stall_o;

  // --------------------------------------------------------------------------
  // Handshake and datapath steering
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    // member_count only changes between items
    cfg_ready_o = (state_q == ST_IDLE);
    rd_addr     = j_q[IDX_W-1:0];
    mul_a       = w_rd;
    mul_b       = best_t_q;
    case (state_q)
      ST_CHECK: begin
        rd_addr = cur_q;
      end
      ST_MUL_B: begin
        // second cross product: written_best * total_j
        mul_a = best_w_q;
        mul_b = t_rd;
      end
      ST_EMIT: begin
        rd_addr = best_q;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Next-state sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && in_data_i.action == ACT_EMIT) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = stay_in_section ? ST_EMIT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_EMIT;
        end else if (rd_unfinished && found_q) begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_CMP;
      ST_CMP:   state_d = ST_SCAN;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [GROUP_W:0]   gt_sum;
  logic [GROUP_W-1:0] gw_inc;
  logic [TOT_W-1:0]   w_inc;

  assign gt_sum = {1'b0, group_total_q} + (GROUP_W + 1)'(in_data_i.member_frames);
  assign gw_inc = (group_written_q == GROUP_MAX) ? group_written_q
                                                 : group_written_q + 1'b1;
  assign w_inc  = w_rd + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      for (int i = 0; i < MEMBERS; i++) begin
        member_total_q[i]   <= '0;
        member_written_q[i] <= '0;
      end
      group_total_q   <= '0;
      group_written_q <= '0;
      cur_q           <= '0;
      sec_open_q      <= 1'b0;
      member_count_q  <= CFG_W'(1);
      out_valid_q     <= 1'b0;
      out_q           <= '0;
      fss_q           <= 1'b0;
      found_q         <= 1'b0;
      j_q             <= '0;
      best_q          <= '0;
      best_t_q        <= '0;
      best_w_q        <= '0;
      prod_a_q        <= '0;
      prod_b_q        <= '0;
      new_sec_q       <= 1'b0;
      err_q           <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        member_count_q <= cfg_data_i;
      end

      // result register drains independently of the sequencer
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            fss_q <= in_data_i.frame_starts_section;
            case (in_data_i.action)
              ACT_LOAD: begin
                // reload replaces the member total but still adds to group
                member_total_q[in_data_i.member_index] <= in_data_i.member_frames;
                group_total_q <= gt_sum[GROUP_W] ? GROUP_MAX : gt_sum[GROUP_W-1:0];
              end
              ACT_RESTART: begin
                for (int i = 0; i < MEMBERS; i++) begin
                  member_written_q[i] <= '0;
                end
                group_written_q <= '0;
                cur_q           <= '0;
                sec_open_q      <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHECK: begin
          best_q    <= cur_q;
          new_sec_q <= 1'b0;
          err_q     <= 1'b0;
          j_q       <= '0;
          found_q   <= 1'b0;
        end
        ST_SCAN: begin
          if (scan_end) begin
            err_q     <= !found_q;
            new_sec_q <= 1'b1;
          end else if (!rd_unfinished) begin
            j_q <= j_q + 1'b1;
          end else if (!found_q) begin
            // first unfinished member is the initial pick
            best_q   <= j_q[IDX_W-1:0];
            best_t_q <= t_rd;
            best_w_q <= w_rd;
            found_q  <= 1'b1;
            j_q      <= j_q + 1'b1;
          end
        end
        ST_MUL_A: prod_a_q <= product;
        ST_MUL_B: prod_b_q <= product;
        ST_CMP: begin
          // w_j/t_j <= w_best/t_best, ties go to the later (higher) index
          if (prod_a_q <= prod_b_q) begin
            best_q   <= j_q[IDX_W-1:0];
            best_t_q <= t_rd;
            best_w_q <= w_rd;
          end
          j_q <= j_q + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            if (err_q) begin
              sec_open_q           <= 1'b0;
              out_q.chosen_member  <= '0;
              out_q.frame_position <= '0;
              out_q.new_section    <= 1'b0;
              out_q.group_done     <= 1'b0;
              out_q.mix_error      <= 1'b1;
            end else begin
              member_written_q[best_q] <= w_inc;
              group_written_q          <= gw_inc;
              cur_q                    <= best_q;
              sec_open_q               <= w_inc < t_rd;
              out_q.chosen_member      <= 3'(best_q);
              out_q.frame_position     <= w_rd[FRAME_COUNT_BITS-1:0];
              out_q.new_section        <= new_sec_q;
              out_q.group_done         <= gw_inc >= group_total_q;
              out_q.mix_error          <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `WSI_ASSERT_NEXT(a_emit_starts_check,
    in_fire && in_data_i.action == ACT_EMIT, state_q == ST_CHECK,
    "emit beat did not start a section check")
  `WSI_ASSERT_NEXT(a_emit_loads_result,
    state_q == ST_EMIT && out_free, out_valid_o && state_q == ST_IDLE,
    "result not presented after emit step")
  `WSI_ASSERT_NOW(a_compare_has_candidate,
    state_q == ST_MUL_A, found_q && j_q < n_eff,
    "cross-multiply started without a valid candidate")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for weighted_section_interleaver. A tracker class keeps
// its own copy of member totals, written counts and section state. It works
// out the frame that every accepted emit beat should produce and checks each
// result beat against the oldest pending frame. Stimulus is a short directed
// run followed by random segments under several member counts and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  import wsi_pkg::*;

  localparam int FRAMES_MAX    = 2 ** TOT_W - 1;
  // hold longer than the worst new-section pick, with margin
  localparam int SETTLE_CYCLES = 40;

  // --------------------------------------------------------------------------
  // Tracker: expected frame schedule plus result checking
  // --------------------------------------------------------------------------
  class mix_tracker;
    logic [TOT_W-1:0]   total [MEMBERS];
    logic [TOT_W-1:0]   written [MEMBERS];
    logic [GROUP_W-1:0] group_total;
    logic [GROUP_W-1:0] group_written;
    int unsigned        current;
    int unsigned        member_count;
    bit                 section_open;
    out_item_t          frames_due [$];
    int                 mismatches;

    function new();
      foreach (total[i]) begin
        total[i]   = '0;
        written[i] = '0;
      end
      group_total   = '0;
      group_written = '0;
      current       = 0;
      section_open  = 1'b0;
      member_count  = 1;
      mismatches    = 0;
    endfunction

    function void set_member_count(logic [CFG_W-1:0] value);
      member_count = 32'(value);
    endfunction

    // Update the schedule for one accepted input beat; emit beats queue a frame.
    function void note_beat(in_item_t beat);
      logic [GROUP_W:0] sum;
      out_item_t        res;
      longint unsigned  lhs, rhs;
      int unsigned      n, pick;
      bit               keep, found;
      case (action_e'(beat.action))
        ACT_LOAD: begin
          // reload replaces the member total but still adds to the group
          total[beat.member_index] = beat.member_frames;
          sum = {1'b0, group_total} + (GROUP_W + 1)'(beat.member_frames);
          group_total = (sum > GROUP_MAX) ? GROUP_MAX : sum[GROUP_W-1:0];
        end
        ACT_RESTART: begin
          foreach (written[i]) written[i] = '0;
          group_written = '0;
          current       = 0;
          section_open  = 1'b0;
        end
        ACT_EMIT: begin
          res = '0;
          n = (member_count > MEMBERS) ? MEMBERS : member_count;
          // stay in the open section unless it ran out or a section start shows
          keep = section_open && current < n && written[current] < total[current]
                 && !beat.frame_starts_section;
          found = keep;
          pick  = current;
          if (!keep) begin
            found = 1'b0;
            pick  = 0;
            // smallest written/total wins; ties go to the later member (<=)
            for (int j = 0; j < n; j++) begin
              if (written[j] < total[j]) begin
                lhs = 64'(written[j]);
                lhs = lhs * 64'(total[pick]);
                rhs = 64'(written[pick]);
                rhs = rhs * 64'(total[j]);
                if (!found || lhs <= rhs) begin
                  pick  = j;
                  found = 1'b1;
                end
              end
            end
          end
          if (!found) begin
            // nothing left to send: error beat, section closes
            section_open  = 1'b0;
            res.mix_error = 1'b1;
          end else begin
            res.chosen_member  = pick[IDX_W-1:0];
            res.frame_position = written[pick][FRAME_COUNT_BITS-1:0];
            res.new_section    = !keep;
            written[pick] = written[pick] + 1'b1;
            if (group_written < GROUP_MAX) group_written = group_written + 1'b1;
            current        = pick;
            section_open   = written[pick] < total[pick];
            res.group_done = group_written >= group_total;
          end
          frames_due.push_back(res);
        end
        default: begin
          // unused action code, no effect
        end
      endcase
    endfunction

    function void report(string what, out_item_t want, out_item_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: exp mbr=%0d pos=%0d new=%b done=%b err=%b",
                 $time, what, want.chosen_member, want.frame_position,
                 want.new_section, want.group_done, want.mix_error);
        $display("%0t %s: got mbr=%0d pos=%0d new=%b done=%b err=%b",
                 $time, what, got.chosen_member, got.frame_position,
                 got.new_section, got.group_done, got.mix_error);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (frames_due.size() == 0) begin
        report("unexpected result", '0, got);
        return;
      end
      want = frames_due.pop_front();
      if (got.chosen_member !== want.chosen_member
          || got.frame_position !== want.frame_position
          || got.new_section !== want.new_section
          || got.group_done !== want.group_done
          || got.mix_error !== want.mix_error) begin
        report("result mismatch", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  int send_idle_pct  = 28;
  int recv_stall_pct = 84;

  mix_tracker tracker;

  always #5 clk_i = ~clk_i;

  weighted_section_interleaver i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // receiver: random back-pressure at the current stall rate
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // result monitor; values seen here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) tracker.check_beat(out_data);
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic in_item_t make_beat(action_e act, int idx, int frames, bit starts);
    in_item_t b;
    b.action               = act;
    b.member_index         = idx[IDX_W-1:0];
    b.member_frames        = frames[TOT_W-1:0];
    b.frame_starts_section = starts;
    return b;
  endfunction

  // Present one beat, hold it through stalls, log it with the tracker on accept.
  task automatic send_beat(in_item_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall);
    tracker.note_beat(b);
  endtask

  // Drop valid, wait for every pending frame, then optionally let the
  // pipeline drain of beats that produce no result.
  task automatic settle(int hold);
    in_valid <= 1'b0;
    while (tracker.frames_due.size() != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  task automatic write_member_count(int value);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_member_count(value[CFG_W-1:0]);
  endtask

  // mostly small totals so members finish; a share of full-range values
  function automatic int load_frames(int big_pct);
    if ($urandom_range(0, 99) < big_pct) return $urandom_range(0, FRAMES_MAX);
    return $urandom_range(0, 4);
  endfunction

  // One random segment: new member count, restart, preload every member,
  // then a random mix dominated by emit beats.
  task automatic play_segment(int count_setting, int beats, int big_pct);
    int r;
    settle(SETTLE_CYCLES);
    write_member_count(count_setting);
    send_beat(make_beat(ACT_RESTART, $urandom_range(0, 7),
                        $urandom_range(0, FRAMES_MAX), 1'($urandom_range(0, 1))));
    for (int m = 0; m < MEMBERS; m++) begin
      send_beat(make_beat(ACT_LOAD, m, load_frames(big_pct), 1'($urandom_range(0, 1))));
    end
    for (int i = 0; i < beats; i++) begin
      // halfway through, hold off the sender until the block has caught up
      if (i == beats / 2) settle(0);
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_beat(make_beat(ACT_EMIT, $urandom_range(0, 7), $urandom_range(0, FRAMES_MAX),
                            $urandom_range(0, 99) < 25));
      end else if (r < 84) begin
        send_beat(make_beat(ACT_LOAD, $urandom_range(0, 7), load_frames(big_pct),
                            1'($urandom_range(0, 1))));
      end else if (r < 87) begin
        send_beat(make_beat(ACT_RESTART, $urandom_range(0, 7),
                            $urandom_range(0, FRAMES_MAX), 1'($urandom_range(0, 1))));
      end else if (r < 91) begin
        send_beat(make_beat(ACT_NONE, $urandom_range(0, 7),
                            $urandom_range(0, FRAMES_MAX), 1'($urandom_range(0, 1))));
      end else begin
        // forced section start: current member gives up its section
        send_beat(make_beat(ACT_EMIT, $urandom_range(0, 7), $urandom_range(0, FRAMES_MAX),
                            1'b1));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset member count of one
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));           // nothing loaded: error
    send_beat(make_beat(ACT_NONE, 7, FRAMES_MAX, 1'b1));  // unused code, ignored
    send_beat(make_beat(ACT_LOAD, 0, 2, 1'b0));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b1));           // opens a section
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));           // group total reached
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));           // all finished: error
    send_beat(make_beat(ACT_RESTART, 0, 0, 1'b0));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));

    // directed, all eight members: zero totals, field extremes, reloads
    settle(SETTLE_CYCLES);
    write_member_count(MEMBERS);
    send_beat(make_beat(ACT_LOAD, 1, 3, 1'b0));
    send_beat(make_beat(ACT_LOAD, 2, 0, 1'b1));
    send_beat(make_beat(ACT_LOAD, 3, 1, 1'b0));
    send_beat(make_beat(ACT_LOAD, 4, 1 << FRAME_COUNT_BITS, 1'b0));
    send_beat(make_beat(ACT_LOAD, 5, FRAMES_MAX, 1'b1));
    send_beat(make_beat(ACT_LOAD, 6, 1, 1'b0));
    send_beat(make_beat(ACT_LOAD, 7, 0, 1'b0));
    send_beat(make_beat(ACT_LOAD, 7, 3, 1'b0));           // reload replaces total
    send_beat(make_beat(ACT_LOAD, 0, 2, 1'b0));
    send_beat(make_beat(ACT_EMIT, 5, FRAMES_MAX, 1'b0));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b1));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b1));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));
    send_beat(make_beat(ACT_RESTART, 7, FRAMES_MAX, 1'b1));
    send_beat(make_beat(ACT_EMIT, 0, 0, 1'b0));

    // random segments; member counts include zero and the 4-bit maximum
    play_segment(MEMBERS, 60, 5);
    play_segment(15, 60, 5);
    send_idle_pct  = 84;
    recv_stall_pct = 28;
    play_segment(0, 30, 5);
    play_segment(3, 60, 5);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // heavier full-range loads here drive the group total into saturation
    play_segment($urandom_range(1, MEMBERS), 70, 30);
    play_segment(MEMBERS, 70, 30);

    settle(SETTLE_CYCLES);
    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
